[design/ptsp_pkg.sv]
// ----------------------------------------------------------------------------
// ptsp_pkg: shared definitions for the pixel to split-plane converter
// Source format codes, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsp_pkg;

  localparam int PIXEL_W     = 32;
  localparam int HIGH_W      = 16;
  localparam int LOW_W       = 8;
  localparam int COMP_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // source layout codes
  typedef enum logic [2:0] {
    FMT_BGR323 = 3'd0,
    FMT_565    = 3'd1,
    FMT_1555   = 3'd2,
    FMT_888    = 3'd3,
    FMT_8888   = 3'd4
  } fmt_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SWAP   = 2'd1;

endpackage

`default_nettype wire

[design/ptsp_pix_if.sv]
// ----------------------------------------------------------------------------
// ptsp_pix_if: source pixel channel
// Valid/ready channel carrying one source pixel word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptsp_pix_if
  import ptsp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

[design/ptsp_plane_if.sv]
// ----------------------------------------------------------------------------
// ptsp_plane_if: split-plane result channel
// Valid/ready channel carrying the 5-6-5 high plane and 3-2-3 low plane.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptsp_plane_if
  import ptsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HIGH_W-1:0] high_plane;
  logic [LOW_W-1:0]  low_plane;

  modport source (output valid, output high_plane, output low_plane, input ready);
  modport sink   (input valid, input high_plane, input low_plane, output ready);
endinterface

`default_nettype wire

[design/pixel_to_split_plane_converter.sv]
// ----------------------------------------------------------------------------
// pixel_to_split_plane_converter: pixel word to 565 + 323 residual planes
// Decodes the configured source layout to 8-bit RGB, optionally swaps red
// and blue, and splits the color into a 5-6-5 high plane and a low residual.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes the stage 1, 2 and 3 registers to its output beat.
// Throughput: one beat per cycle; the three stage registers each stall
//   only when the stage ahead is full and blocked.
// Reset (rst_n low, synchronous): stage valid bits clear, source_format
//   returns to bgr323 and swap_red_blue to off.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_split_plane_converter
  import ptsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  ptsp_pix_if.sink                   in_pix,
  ptsp_plane_if.source               out_plane
);

  // widen narrow components by replicating their top bits
  function automatic logic [COMP_W-1:0] widen3(input logic [2:0] v);
    widen3 = {v, v, v[2:1]};
  endfunction

  function automatic logic [COMP_W-1:0] widen2(input logic [1:0] v);
    widen2 = {v, v, v, v};
  endfunction

  function automatic logic [COMP_W-1:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [COMP_W-1:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  // configuration registers
  fmt_t fmt_cfg_r;
  logic swap_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cfg_r  <= FMT_BGR323;
      swap_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_IDX_FORMAT) begin
        fmt_cfg_r <= fmt_t'(cfg_wdata[2:0]);
      end
      if (cfg_idx == CFG_IDX_SWAP) begin
        swap_cfg_r <= cfg_wdata[0];
      end
    end
  end

  // stage registers and handshake
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic               s1_ld, s2_ld, s3_ld;
  logic [PIXEL_W-1:0] pix1_r;
  fmt_t               fmt1_r;
  logic               swap1_r, swap2_r;
  logic [COMP_W-1:0]  red2_r, grn2_r, blu2_r;
  logic [COMP_W-1:0]  red2_nxt, grn2_nxt, blu2_nxt;
  logic [COMP_W-1:0]  red3, blu3;
  logic [HIGH_W-1:0]  high3_r;
  logic [LOW_W-1:0]   low3_r;

  assign s3_ld        = !s3_v_r || out_plane.ready;
  assign s2_ld        = !s2_v_r || s3_ld;
  assign s1_ld        = !s1_v_r || s2_ld;
  assign in_pix.ready = s1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= in_pix.valid;
      if (s2_ld) s2_v_r <= s1_v_r;
      if (s3_ld) s3_v_r <= s2_v_r;
    end
  end

  // stage 1: capture pixel with the settings it is converted under
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      pix1_r  <= in_pix.pixel_word;
      fmt1_r  <= fmt_cfg_r;
      swap1_r <= swap_cfg_r;
    end
  end

  // stage 2: layout decode to 8-bit components
  always_comb begin
    red2_nxt = '0;
    grn2_nxt = '0;
    blu2_nxt = '0;
    unique case (fmt1_r) inside
      FMT_BGR323: begin
        red2_nxt = widen3(pix1_r[2:0]);
        grn2_nxt = widen2(pix1_r[4:3]);
        blu2_nxt = widen3(pix1_r[7:5]);
      end
      FMT_565: begin
        red2_nxt = widen5(pix1_r[4:0]);
        grn2_nxt = widen6(pix1_r[10:5]);
        blu2_nxt = widen5(pix1_r[15:11]);
      end
      FMT_1555: begin
        red2_nxt = widen5(pix1_r[4:0]);
        grn2_nxt = widen5(pix1_r[9:5]);
        blu2_nxt = widen5(pix1_r[14:10]);
      end
      FMT_888, FMT_8888: begin
        red2_nxt = pix1_r[7:0];
        grn2_nxt = pix1_r[15:8];
        blu2_nxt = pix1_r[23:16];
      end
      default: begin
        // unknown layout decodes to black
        red2_nxt = '0;
        grn2_nxt = '0;
        blu2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      red2_r  <= red2_nxt;
      grn2_r  <= grn2_nxt;
      blu2_r  <= blu2_nxt;
      swap2_r <= swap1_r;
    end
  end

  // stage 3: red/blue swap and plane packing
  assign red3 = swap2_r ? blu2_r : red2_r;
  assign blu3 = swap2_r ? red2_r : blu2_r;

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      high3_r <= {red3[7:3], grn2_r[7:2], blu3[7:3]};
      low3_r  <= {red3[2:0], grn2_r[1:0], blu3[2:0]};
    end
  end

  assign out_plane.valid      = s3_v_r;
  assign out_plane.high_plane = high3_r;
  assign out_plane.low_plane  = low3_r;

  // checks
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (s1_v_r && s2_v_r && s3_v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_ld) |=> ($stable(red2_r) && $stable(grn2_r) && $stable(blu2_r)))
    else $error("decode stage changed while stalled");

  // codes above the last named layout are unknown
  a_unknown_black: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_ld && s1_v_r && (fmt1_r > FMT_8888))
    |=> (red2_r == '0 && grn2_r == '0 && blu2_r == '0))
    else $error("unknown layout did not decode to black");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> s1_v_r)
    else $error("accepted beat lost at stage 1");

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for pixel_to_split_plane_converter
// Covers every source layout code (including the unused ones that decode to
// black) with red/blue swap on and off. Each accepted pixel beat is turned
// into its 5-6-5 high plane and 3-2-3 residual by a local decoder, and the
// result beats are compared in order, under random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ptsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed: layout codes that decode to black and
  // a register index that maps to nothing
  localparam logic [2:0] FMT_RSVD_5 = 3'd5;
  localparam logic [2:0] FMT_RSVD_6 = 3'd6;
  localparam logic [2:0] FMT_RSVD_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam logic [2:0] FMT_CODES [8] = '{FMT_BGR323, FMT_565, FMT_1555, FMT_888,
                                           FMT_8888, FMT_RSVD_5, FMT_RSVD_6, FMT_RSVD_7};

  localparam int STALL_LIMIT  = 1000;
  localparam int PIPE_LATENCY = 3;
  localparam int RAND_PHASES  = 16;

  typedef struct packed {
    logic [HIGH_W-1:0] high_plane;
    logic [LOW_W-1:0]  low_plane;
  } planes_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptsp_pix_if   pix();
  ptsp_plane_if plane();

  pixel_to_split_plane_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix.sink),
    .out_plane (plane.source)
  );

  // shadow of the configuration registers
  logic [2:0] cur_fmt;
  logic       cur_swap;

  logic [PIXEL_W-1:0] pending_pixels [$];
  planes_t            expected_planes [$];

  int pixels_sent;
  int planes_checked;
  int mismatches;
  int settings_used;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // decode one pixel word to 8-bit RGB, optional swap, then split the planes
  function automatic planes_t split_pixel(logic [PIXEL_W-1:0] w, logic [2:0] fmt,
                                          logic swap);
    logic [COMP_W-1:0] r, g, b;
    planes_t           p;
    r = '0;
    g = '0;
    b = '0;
    case (fmt)
      FMT_BGR323: begin
        r = {w[2:0], w[2:0], w[2:1]};
        g = {4{w[4:3]}};
        b = {w[7:5], w[7:5], w[7:6]};
      end
      FMT_565: begin
        r = {w[4:0], w[4:2]};
        g = {w[10:5], w[10:9]};
        b = {w[15:11], w[15:13]};
      end
      FMT_1555: begin
        r = {w[4:0], w[4:2]};
        g = {w[9:5], w[9:7]};
        b = {w[14:10], w[14:12]};
      end
      FMT_888, FMT_8888: begin
        r = w[7:0];
        g = w[15:8];
        b = w[23:16];
      end
      default: ;  // unused codes decode to black
    endcase
    if (swap) {r, b} = {b, r};
    p.high_plane = {r[7:3], g[7:2], b[7:3]};
    p.low_plane  = {r[2:0], g[1:0], b[2:0]};
    return p;
  endfunction

  // mix of all-zero, all-one, low-16-bits-only and fully random words
  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom() & 32'h0000FFFF;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      pix.valid      <= 1'b0;
      pix.pixel_word <= '0;
      burst_left     = $urandom_range(1, 40);
      gap_left       = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_planes.push_back(split_pixel(pix.pixel_word, cur_fmt, cur_swap));
        pixels_sent++;
      end
      if (!pix.valid || pix.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          pix.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          pix.valid      <= 1'b1;
          pix.pixel_word <= pending_pixels.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // plane monitor: checks each result beat, drives ready on its own pattern
  // ---------------------------------------------------------------------------
  rx_mode_t   rx_mode;
  int         rx_mode_left;
  logic [7:0] stall_mask;

  always @(posedge clk) begin
    planes_t exp_p;
    if (!rst_n) begin
      plane.ready  <= 1'b0;
      rx_mode      = RX_OPEN;
      rx_mode_left = 0;
      stall_mask   = 8'hFF;
    end else begin
      if (plane.valid && plane.ready) begin
        if (expected_planes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result beat with nothing pending: high %h low %h",
                     plane.high_plane, plane.low_plane);
        end else begin
          exp_p = expected_planes.pop_front();
          planes_checked++;
          if (plane.high_plane !== exp_p.high_plane ||
              plane.low_plane !== exp_p.low_plane) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: beat %0d: high exp %h got %h, low exp %h got %h",
                       planes_checked, exp_p.high_plane, plane.high_plane,
                       exp_p.low_plane, plane.low_plane);
          end
        end
      end
      // pick a new back-pressure style now and then
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(16, 160);
        stall_mask   = 8'($urandom_range(1, 255));
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   plane.ready <= 1'b1;
        RX_RANDOM: plane.ready <= 1'($urandom_range(0, 1));
        default: begin
          plane.ready <= stall_mask[0];
          stall_mask  = {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  // watchdog: no beat moving on either side for too long
  int idle_cycles;

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (plane.valid && plane.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus control
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_pixels.size() != 0 || pix.valid || expected_planes.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_IDX_FORMAT)
      cur_fmt = val;
    else if (idx == CFG_IDX_SWAP)
      cur_swap = val[0];
  endtask

  // swap data carries random upper bits, which the register drops
  task automatic apply_setting(logic [2:0] fmt, logic swap);
    wait_drained();
    repeat (PIPE_LATENCY + 1) @(posedge clk);
    write_reg(CFG_IDX_FORMAT, fmt);
    write_reg(CFG_IDX_SWAP, {2'($urandom_range(0, 3)), swap});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_pixels(logic [PIXEL_W-1:0] words [$]);
    foreach (words[i]) pending_pixels.push_back(words[i]);
  endtask

  initial begin
    int n_items;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    pix.valid      = 1'b0;
    pix.pixel_word = '0;
    plane.ready    = 1'b0;
    cur_fmt        = FMT_BGR323;
    cur_swap       = 1'b0;
    pixels_sent    = 0;
    planes_checked = 0;
    mismatches     = 0;
    settings_used  = 1;
    idle_cycles    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset layout is bgr323, no swap; high bits must be ignored
    queue_pixels('{32'h0000_0000, 32'h0000_00FF, 32'h0000_00A5, 32'hFFFF_FF5A});

    // 565 field edges, upper half ignored
    apply_setting(FMT_565, 1'b0);
    queue_pixels('{32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'hFFFF_0821});

    // 1555 with swap: top bit alone, blue and green fields alone, red field with top bit
    apply_setting(FMT_1555, 1'b1);
    queue_pixels('{32'h0000_8000, 32'h0000_7C00, 32'h0000_03E0, 32'h0000_801F});

    // a write to an unmapped index must leave the layout alone
    wait_drained();
    write_reg(CFG_IDX_UNUSED, FMT_888);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    queue_pixels('{32'h0000_FFFF});

    apply_setting(FMT_888, 1'b0);
    queue_pixels('{32'h00FF_FFFF, 32'hFF12_3456});

    // alpha byte ignored
    apply_setting(FMT_8888, 1'b1);
    queue_pixels('{32'hFF00_00FF, 32'h00AB_CDEF});

    // unused layout codes give black, with or without swap
    apply_setting(FMT_RSVD_5, 1'b1);
    queue_pixels('{32'hFFFF_FFFF});
    apply_setting(FMT_RSVD_7, 1'b0);
    queue_pixels('{32'hFFFF_FFFF});

    // random phases: every layout code with swap off and on
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_setting(FMT_CODES[ph % 8], (ph < 8) ? ph[0] : !ph[0]);
      n_items = $urandom_range(40, 66);
      repeat (n_items) pending_pixels.push_back(random_pixel());
    end

    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    $display("Converted %0d pixel beats across %0d register settings (all layout codes,",
             pixels_sent, settings_used);
    $display("swap off and on); %0d result beats checked, %0d mismatches.",
             planes_checked, mismatches);
    if (mismatches == 0 && expected_planes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
